// File: design/utd_pkg.sv
package utd_pkg;

  // Pipeline depth: one register rank per stage
  localparam int STAGES = 9;

  // Field widths
  localparam int SECS_W    = 32;
  localparam int YEAR_W    = 12;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int HOURS_W   = 5;
  localparam int MINUTES_W = 6;
  localparam int SECONDS_W = 6;
  localparam int WEEKDAY_W = 3;

  // Internal widths shared between modules
  localparam int DAYS_W = 16;  // whole days since epoch, at most 49710
  localparam int REM_W  = 17;  // seconds into the day, below 86400

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic [STAGES-1:0] load;
  } utd_ctrl_t;

endpackage

// File: design/utd_pipe_ctrl.sv
module utd_pipe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output utd_pkg::utd_ctrl_t  ctrl
);

  localparam int S = utd_pkg::STAGES;

  logic [S-1:0] vld;
  logic [S-1:0] vld_next;
  logic [S-1:0] ready;
  logic         in_acc;
  logic         out_acc;

  // A stage can take new data when it is empty or its successor moves on
  always_comb begin
    ready[S-1] = !vld[S-1] || !out_stall;
    for (int k = S - 2; k >= 0; k--) begin
      ready[k] = !vld[k] || ready[k+1];
    end
  end

  // Valid bits follow the data
  always_comb begin
    vld_next[0] = ready[0] ? in_valid : vld[0];
    for (int k = 1; k < S; k++) begin
      vld_next[k] = ready[k] ? vld[k-1] : vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign ctrl.load = ready;
  assign in_stall  = !ready[0];
  assign out_valid = vld[S-1];
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // Occupancy changes only by transfers at the two ends
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones(vld) ==
      $countones($past(vld)) + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("pipeline occupancy does not match transfers");

  // Input is held back only when every stage is full
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld))
    else $error("input stalled while a stage is empty");

  // A held result is never overwritten
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (vld[S-1] && out_stall) |-> !ctrl.load[S-1])
    else $error("last stage loaded while result is held");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0))
    else $error("pipeline not empty after reset");

endmodule

// File: design/utd_day_split.sv
module utd_day_split (
  input  logic                               clk,
  input  utd_pkg::utd_ctrl_t                 ctrl,
  input  logic [utd_pkg::SECS_W-1:0]         unix_seconds,
  output logic [utd_pkg::DAYS_W-1:0]         days_s1,
  output logic [utd_pkg::REM_W-1:0]          rem_s2
);

  // floor(t/86400) = floor(floor(t/128)/675), reciprocal of 675 at 2^35
  localparam logic [25:0] DAY_RECIP = 26'd50903317;
  localparam int          DAY_SHIFT = 35;

  logic [24:0]                 secs_hi;
  logic [50:0]                 day_prod;
  logic [utd_pkg::SECS_W-1:0]  secs_s1;
  logic [32:0]                 day_base;
  logic [31:0]                 rem_diff;

  // Stage 1: day count
  assign secs_hi  = unix_seconds[31:7];
  assign day_prod = {26'd0, secs_hi} * {25'd0, DAY_RECIP};

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      days_s1 <= day_prod[DAY_SHIFT +: utd_pkg::DAYS_W];
      secs_s1 <= unix_seconds;
    end
  end

  // Stage 2: seconds into the day
  assign day_base = {17'd0, days_s1} * 33'd86400;
  assign rem_diff = secs_s1 - day_base[31:0];

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      rem_s2 <= rem_diff[utd_pkg::REM_W-1:0];
    end
  end

endmodule

// File: design/utd_time_of_day.sv
module utd_time_of_day (
  input  logic                               clk,
  input  utd_pkg::utd_ctrl_t                 ctrl,
  input  logic [utd_pkg::REM_W-1:0]          rem_s2,
  output logic [utd_pkg::HOURS_W-1:0]        hours,
  output logic [utd_pkg::MINUTES_W-1:0]      minutes,
  output logic [utd_pkg::SECONDS_W-1:0]      seconds
);

  // Reciprocals: 3600 at 2^29, 60 at 2^18
  localparam logic [17:0] HOUR_RECIP = 18'd149131;
  localparam int          HOUR_SHIFT = 29;
  localparam logic [12:0] MIN_RECIP  = 13'd4370;
  localparam int          MIN_SHIFT  = 18;

  typedef struct packed {
    logic [utd_pkg::HOURS_W-1:0]   hr;
    logic [utd_pkg::MINUTES_W-1:0] mn;
    logic [utd_pkg::SECONDS_W-1:0] sc;
  } hms_t;

  logic [34:0]                     hr_prod;
  logic [utd_pkg::REM_W-1:0]       rem_s3;
  logic [utd_pkg::HOURS_W-1:0]     hr_s3, hr_s4, hr_s5;
  logic [utd_pkg::REM_W-1:0]       hr_base;
  logic [utd_pkg::REM_W-1:0]       rem2_diff;
  logic [11:0]                     rem2_s4, rem2_s5;
  logic [24:0]                     min_prod;
  logic [utd_pkg::MINUTES_W-1:0]   min_s5;
  logic [11:0]                     sec_base;
  logic [11:0]                     sec_diff;
  hms_t                            hms_s6, hms_s7, hms_s8;

  // Stage 3: hour
  assign hr_prod = {18'd0, rem_s2} * {17'd0, HOUR_RECIP};

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      hr_s3  <= hr_prod[HOUR_SHIFT +: utd_pkg::HOURS_W];
      rem_s3 <= rem_s2;
    end
  end

  // Stage 4: seconds into the hour
  assign hr_base   = {12'd0, hr_s3} * 17'd3600;
  assign rem2_diff = rem_s3 - hr_base;

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      rem2_s4 <= rem2_diff[11:0];
      hr_s4   <= hr_s3;
    end
  end

  // Stage 5: minute
  assign min_prod = {13'd0, rem2_s4} * {12'd0, MIN_RECIP};

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      min_s5  <= min_prod[MIN_SHIFT +: utd_pkg::MINUTES_W];
      rem2_s5 <= rem2_s4;
      hr_s5   <= hr_s4;
    end
  end

  // Stage 6: second
  assign sec_base = {6'd0, min_s5} * 12'd60;
  assign sec_diff = rem2_s5 - sec_base;

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      hms_s6.hr <= hr_s5;
      hms_s6.mn <= min_s5;
      hms_s6.sc <= sec_diff[utd_pkg::SECONDS_W-1:0];
    end
  end

  // Stages 7 to 9: keep in step with the date path
  always_ff @(posedge clk) begin
    if (ctrl.load[6]) begin
      hms_s7 <= hms_s6;
    end
    if (ctrl.load[7]) begin
      hms_s8 <= hms_s7;
    end
    if (ctrl.load[8]) begin
      hours   <= hms_s8.hr;
      minutes <= hms_s8.mn;
      seconds <= hms_s8.sc;
    end
  end

endmodule

// File: design/utd_calendar.sv
module utd_calendar (
  input  logic                               clk,
  input  utd_pkg::utd_ctrl_t                 ctrl,
  input  logic [utd_pkg::DAYS_W-1:0]         days_s1,
  output logic [utd_pkg::YEAR_W-1:0]         year,
  output logic [utd_pkg::MONTH_W-1:0]        month,
  output logic [utd_pkg::DAY_W-1:0]          day,
  output logic [utd_pkg::WEEKDAY_W-1:0]      weekday
);

  // Reciprocals: 7305 at 2^39, 100 at 2^19, 7 at 2^12, 13*205 for 26e/10
  localparam logic [26:0] YR_RECIP   = 27'd75257470;
  localparam int          YR_SHIFT   = 39;
  localparam logic [12:0] CENT_RECIP = 13'd5243;
  localparam int          CENT_SHIFT = 19;
  localparam logic [9:0]  MOD7_RECIP = 10'd586;
  localparam int          MOD7_SHIFT = 12;
  localparam logic [11:0] MD_RECIP   = 12'd2665;
  localparam int          MD_SHIFT   = 10;

  // Month number e from day of shifted year: count of 30.601-day marks passed
  function automatic logic [3:0] month_index(logic [8:0] dd);
    logic [19:0] scaled;
    logic [3:0]  cnt;
    scaled = {11'd0, dd} * 20'd1000;
    cnt    = '0;
    for (int j = 1; j < 16; j++) begin
      if (scaled >= 20'(30601 * j)) begin
        cnt = cnt + 4'd1;
      end
    end
    return cnt;
  endfunction

  // Days before month e: 30e + floor(0.601e)
  function automatic logic [8:0] month_offset(logic [3:0] e);
    logic [8:0] off;
    case (e)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd30;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd91;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd183;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd244;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd336;
      4'd12:   off = 9'd367;
      4'd13:   off = 9'd397;
      4'd14:   off = 9'd428;
      4'd15:   off = 9'd459;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  logic [18:0] cyc_num;
  logic [4:0]  a_corr;
  logic [21:0] b_sum;
  logic [21:0] b_s2, b_s3, b_s4;
  logic [26:0] cnum_full;
  logic [25:0] cnum_s3;
  logic [52:0] c_prod;
  logic [12:0] c_s4, c_s5, c_s6;
  logic [21:0] dd_full;
  logic [8:0]  dd_s5, dd_s6;
  logic [3:0]  e_s6;
  logic [8:0]  f_full;
  logic [11:0] yz;
  logic [24:0] cen_prod;
  logic [15:0] md_prod;
  logic [utd_pkg::DAY_W-1:0]   day_s7, day_s8;
  logic [utd_pkg::MONTH_W-1:0] month_s7, month_s8;
  logic [utd_pkg::YEAR_W-1:0]  year_s7, year_s8;
  logic [11:0] yz_s7;
  logic [4:0]  cen_s7;
  logic [5:0]  md_s7;
  logic [11:0] cen_base;
  logic [11:0] yoc_diff;
  logic [6:0]  yoc;
  logic [8:0]  h_sum;
  logic [8:0]  h_s8;
  logic [8:0]  wx;
  logic [18:0] q7_prod;
  logic [8:0]  q7_base;
  logic [8:0]  r7;

  // Stage 2: Gregorian century correction, then shifted day number
  assign cyc_num = {1'b0, days_s1, 2'b00} + 19'd102032;
  always_comb begin
    if (cyc_num >= 19'd292194) begin
      a_corr = 5'd17;
    end else if (cyc_num >= 19'd146097) begin
      a_corr = 5'd16;
    end else begin
      a_corr = 5'd15;
    end
  end
  assign b_sum = {6'd0, days_s1} + 22'd2442113 + {17'd0, a_corr}
               - {19'd0, a_corr[4:2]};

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      b_s2 <= b_sum;
    end
  end

  // Stage 3: numerator of the year estimate
  assign cnum_full = {5'd0, b_s2} * 27'd20 - 27'd2442;

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      cnum_s3 <= cnum_full[25:0];
      b_s3    <= b_s2;
    end
  end

  // Stage 4: year estimate c
  assign c_prod = {27'd0, cnum_s3} * {26'd0, YR_RECIP};

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      c_s4 <= c_prod[YR_SHIFT +: 13];
      b_s4 <= b_s3;
    end
  end

  // Stage 5: day within the shifted year
  assign dd_full = b_s4 - {9'd0, c_s4} * 22'd365 - {11'd0, c_s4[12:2]};

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      dd_s5 <= dd_full[8:0];
      c_s5  <= c_s4;
    end
  end

  // Stage 6: month index
  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      e_s6  <= month_index(dd_s5);
      dd_s6 <= dd_s5;
      c_s6  <= c_s5;
    end
  end

  // Stage 7: day, month, year; Zeller terms (March-based year is c - 4716)
  assign f_full   = dd_s6 - month_offset(e_s6);
  assign yz       = 12'(c_s6 - 13'd4716);
  assign cen_prod = {13'd0, yz} * {12'd0, CENT_RECIP};
  assign md_prod  = {12'd0, e_s6} * {4'd0, MD_RECIP};

  always_ff @(posedge clk) begin
    if (ctrl.load[6]) begin
      day_s7 <= f_full[utd_pkg::DAY_W-1:0];
      if (e_s6 <= 4'd13) begin
        month_s7 <= e_s6 - 4'd1;
        year_s7  <= yz;
      end else begin
        month_s7 <= e_s6 - 4'd13;
        year_s7  <= yz + 12'd1;
      end
      yz_s7  <= yz;
      cen_s7 <= cen_prod[CENT_SHIFT +: 5];
      md_s7  <= md_prod[MD_SHIFT +: 6];
    end
  end

  // Stage 8: Zeller sum
  assign cen_base = {7'd0, cen_s7} * 12'd100;
  assign yoc_diff = yz_s7 - cen_base;
  assign yoc      = yoc_diff[6:0];
  assign h_sum    = {4'd0, day_s7} + {3'd0, md_s7} + {2'd0, yoc} + {4'd0, yoc[6:2]}
                  + {4'd0, cen_s7} * 9'd5 + {6'd0, cen_s7[4:2]};

  always_ff @(posedge clk) begin
    if (ctrl.load[7]) begin
      h_s8     <= h_sum;
      day_s8   <= day_s7;
      month_s8 <= month_s7;
      year_s8  <= year_s7;
    end
  end

  // Stage 9: weekday = ((h + 5) mod 7) + 1
  assign wx      = h_s8 + 9'd5;
  assign q7_prod = {10'd0, wx} * {9'd0, MOD7_RECIP};
  assign q7_base = {3'd0, q7_prod[MOD7_SHIFT +: 6]} * 9'd7;
  assign r7      = wx - q7_base;

  always_ff @(posedge clk) begin
    if (ctrl.load[8]) begin
      year    <= year_s8;
      month   <= month_s8;
      day     <= day_s8;
      weekday <= r7[utd_pkg::WEEKDAY_W-1:0] + 3'd1;
    end
  end

endmodule

// File: design/unix_seconds_to_date.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall   | unix_seconds[31:0]
// out     | output    | out_valid / out_stall | year, month, day, hours, minutes,
//         |           |                       | seconds, weekday
//
// Nine register stages: a result is on the outputs once it has been loaded into
// the last stage register. Throughput is one transfer per cycle while out_stall
// is low; each stage holds about one constant multiply and one wide subtract.
// Reset (rst, synchronous) empties the pipeline; data registers are not reset.
// A stall on the output holds the last stage; earlier stages keep filling any
// empty slots, so in_stall rises only when all nine stages hold data.
module unix_seconds_to_date (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [utd_pkg::SECS_W-1:0]         unix_seconds,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [utd_pkg::YEAR_W-1:0]         year,
  output logic [utd_pkg::MONTH_W-1:0]        month,
  output logic [utd_pkg::DAY_W-1:0]          day,
  output logic [utd_pkg::HOURS_W-1:0]        hours,
  output logic [utd_pkg::MINUTES_W-1:0]      minutes,
  output logic [utd_pkg::SECONDS_W-1:0]      seconds,
  output logic [utd_pkg::WEEKDAY_W-1:0]      weekday
);

  utd_pkg::utd_ctrl_t               ctrl;
  logic [utd_pkg::DAYS_W-1:0]       days_s1;
  logic [utd_pkg::REM_W-1:0]        rem_s2;

  // Stage enables and valid tracking
  utd_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  // Days and seconds-of-day
  utd_day_split u_split (
    .clk          (clk),
    .ctrl         (ctrl),
    .unix_seconds (unix_seconds),
    .days_s1      (days_s1),
    .rem_s2       (rem_s2)
  );

  // Hours, minutes, seconds
  utd_time_of_day u_tod (
    .clk     (clk),
    .ctrl    (ctrl),
    .rem_s2  (rem_s2),
    .hours   (hours),
    .minutes (minutes),
    .seconds (seconds)
  );

  // Year, month, day, weekday
  utd_calendar u_cal (
    .clk     (clk),
    .ctrl    (ctrl),
    .days_s1 (days_s1),
    .year    (year),
    .month   (month),
    .day     (day),
    .weekday (weekday)
  );

endmodule
